>>> rtl/brfc_pkg.sv
// Shared types and constants for the bracket range fix counter.
package brfc_pkg;

  localparam int unsigned MAX_LEN_DEF = 1024;
  localparam int unsigned POS_W       = 11;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned OP_W        = 2;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_FLIP  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    logic load;       // capture query bounds, clear counters
    logic mem_wr_in;  // write incoming bracket
    logic flip_rd;    // read entry to be flipped
    logic flip_wr;    // write inverted entry back
    logic scan_rd;    // read next entry of the range, advance index
    logic emit;       // register the count and raise the strobe
  } brfc_cmd_t;

  typedef struct packed {
    logic pos_ok;
    logic range_empty;
    logic scan_last;
  } brfc_sts_t;

endpackage

>>> rtl/brfc_ctrl.sv
// Sequencing state machine for the bracket range fix counter.
module brfc_ctrl
  import brfc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic [OP_W-1:0] operation_i,
  input  brfc_sts_t       sts_i,
  output brfc_cmd_t       cmd_o,
  output logic            busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FLIP  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (operation_i)
            OP_WRITE: begin
              cmd_o.mem_wr_in = sts_i.pos_ok;
            end
            OP_FLIP: begin
              if (sts_i.pos_ok) begin
                cmd_o.flip_rd = 1'b1;
                state_d       = S_FLIP;
              end
            end
            OP_QUERY: begin
              cmd_o.load = 1'b1;
              state_d    = sts_i.range_empty ? S_FIN : S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_FLIP: begin
        cmd_o.flip_wr = 1'b1;
        state_d       = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/brfc_dp.sv
// Datapath: bracket memory, scan index, depth and unmatched counters.
module brfc_dp
  import brfc_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [POS_W-1:0] position_i,
  input  logic [POS_W-1:0] right_end_i,
  input  logic             bracket_in_i,
  input  brfc_cmd_t        cmd_i,
  output brfc_sts_t        sts_o,
  output logic             out_valid_o,
  output logic [CNT_W-1:0] fix_count_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned XW = (AW + 1 > POS_W) ? AW + 1 : POS_W;
  localparam logic [XW-1:0] LIMIT = XW'(MAX_LEN);
  localparam logic [XW-1:0] ONE_X = XW'(1);

  logic             mem_q [MAX_LEN];
  logic             rdata_q;
  logic             rvld_q;
  logic [AW-1:0]    addr_q;
  logic [POS_W-1:0] idx_q, idx_d;
  logic [POS_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0] unm_q, unm_d;
  logic [CNT_W-1:0] res_q;
  logic             out_vld_q;

  logic [XW-1:0]    pos_x, pos_m1, idx_m1, rend_x, hi_x;
  logic [POS_W-1:0] lo_in, hi_in;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_en, wr_data;
  logic [CNT_W:0]   sum;

  // Decode incoming position and clip the query range to the store
  assign pos_x  = XW'(position_i);
  assign pos_m1 = pos_x - ONE_X;
  assign rend_x = XW'(right_end_i);
  assign hi_x   = (rend_x > LIMIT) ? LIMIT : rend_x;
  assign hi_in  = hi_x[POS_W-1:0];
  assign lo_in  = (position_i == '0) ? POS_W'(1) : position_i;
  assign idx_m1 = XW'(idx_q) - ONE_X;

  assign sts_o.pos_ok      = (pos_x != '0) && (pos_x <= LIMIT);
  assign sts_o.range_empty = (lo_in > hi_in);
  assign sts_o.scan_last   = (idx_q == hi_q);

  assign rd_addr = cmd_i.scan_rd ? idx_m1[AW-1:0] : pos_m1[AW-1:0];
  assign wr_en   = cmd_i.mem_wr_in | cmd_i.flip_wr;
  assign wr_addr = cmd_i.flip_wr ? addr_q : pos_m1[AW-1:0];
  assign wr_data = cmd_i.flip_wr ? ~rdata_q : bracket_in_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    idx_d   = idx_q;
    hi_d    = hi_q;
    depth_d = depth_q;
    unm_d   = unm_q;
    if (cmd_i.load) begin
      idx_d   = lo_in;
      hi_d    = hi_in;
      depth_d = '0;
      unm_d   = '0;
    end else begin
      if (cmd_i.scan_rd) begin
        idx_d = idx_q + POS_W'(1);
      end
      // Fold in the bracket read last cycle
      if (rvld_q) begin
        if (rdata_q) begin
          if (depth_q != '0) begin
            depth_d = depth_q - CNT_W'(1);
          end else begin
            unm_d = unm_q + CNT_W'(1);
          end
        end else begin
          depth_d = depth_q + CNT_W'(1);
        end
      end
    end
  end

  assign sum = {1'b0, depth_q} + {1'b0, unm_q};

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    hi_q    <= hi_d;
    depth_q <= depth_d;
    unm_q   <= unm_d;
    if (cmd_i.flip_rd) begin
      addr_q <= pos_m1[AW-1:0];
    end
    if (cmd_i.emit) begin
      res_q <= sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rvld_q    <= cmd_i.scan_rd;
      out_vld_q <= cmd_i.emit;
    end
  end

  assign out_valid_o = out_vld_q;
  assign fix_count_o = res_q;

endmodule

>>> rtl/bracket_range_fix_counter.sv
// Top level of the bracket range fix counter: controller plus datapath.
//
// Usage: hold operation_i, position_i, right_end_i and bracket_in_i with
// start high; the beat is taken at the edge where busy is low. A write
// (store one bracket, 0 opening, 1 closing) completes in the accepting
// cycle and busy stays low, so writes may follow every cycle. A flip
// reads its entry when accepted and writes it back inverted in S_FLIP,
// since the bracket memory read is registered; busy is high for one
// cycle. Writes or flips outside 1..MAX_LEN are dropped.
// A query l..r walks the clipped range one memory entry a cycle: busy is
// high in S_SCAN, S_DRAIN and S_FIN (S_FIN alone for an empty range), and
// the result beat shows on fix_count_o with out_valid_o high for exactly
// one cycle once busy is low; the next command may be taken in that cycle.
// Throughput is bound by the memory read port: one bracket per cycle.
// There is no back-pressure on the result side; the receiver must take
// the beat in the cycle it is shown.
// Reset clears the controller and strobes; memory contents are undefined
// until written and need no clearing pass.
module bracket_range_fix_counter
  import brfc_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [POS_W-1:0] position_i,
  input  logic [POS_W-1:0] right_end_i,
  input  logic             bracket_in_i,
  output logic             out_valid_o,
  output logic [CNT_W-1:0] fix_count_o
);

  brfc_cmd_t cmd;
  brfc_sts_t sts;

  // Sequence commands: one-hot controller
  brfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  // Hold the bracket string and advance the scan counters
  brfc_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .position_i   (position_i),
    .right_end_i  (right_end_i),
    .bracket_in_i (bracket_in_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .fix_count_o  (fix_count_o)
  );

endmodule

>>> sim/tb.sv
// Self-checking testbench for the bracket range fix counter: random and directed commands.
module tb
  import brfc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN     = MAX_LEN_DEF;
  localparam int POS_TOP     = (1 << POS_W) - 1;  // largest value of a position field
  localparam int ITEM_TARGET = 580;
  localparam int CALM_FROM   = 200;                // beats in this window see no gaps
  localparam int CALM_TO     = 330;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;    // no operation behind this code

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] rend;
    logic             bit_in;
  } bracket_cmd_t;

  // Block ports; every input holds a known value from time zero.
  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cmd_start    = 1'b0;
  logic             busy;
  logic [OP_W-1:0]  cmd_op       = '0;
  logic [POS_W-1:0] cmd_pos      = '0;
  logic [POS_W-1:0] cmd_rend     = '0;
  logic             cmd_bit      = 1'b0;
  logic             out_valid_o;
  logic [CNT_W-1:0] fix_count_o;

  bracket_cmd_t     cmd_backlog[$];  // commands waiting for the driver
  bracket_cmd_t     next_cmd;
  logic [CNT_W-1:0] count_due[$];    // predicted fix counts, oldest first
  bit               bracket_img [1:MAX_LEN];  // mirror of the bracket memory, 1 closing
  bit               loaded      [1:MAX_LEN];  // positions the generator has written so far
  bit               beat_taken = 1'b0;        // set at the edge that took a beat

  int fail_count = 0;
  int n_beats    = 0;
  int n_write    = 0;
  int n_flip     = 0;
  int n_query    = 0;
  int n_idle_op  = 0;
  int n_checked  = 0;
  int widest     = 0;

  bracket_range_fix_counter #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (cmd_start),
    .busy        (busy),
    .operation_i (cmd_op),
    .position_i  (cmd_pos),
    .right_end_i (cmd_rend),
    .bracket_in_i(cmd_bit),
    .out_valid_o (out_valid_o),
    .fix_count_o (fix_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Scan l..r once, clipped to the store: closers with no opener waiting count as
  // unmatched, and whatever depth is left over at the end adds to the count.
  function automatic logic [CNT_W-1:0] unmatched_in(int lo, int hi);
    int depth;
    int stray;
    int tot;
    depth = 0;
    stray = 0;
    if (lo < 1) lo = 1;
    if (hi > MAX_LEN) hi = MAX_LEN;
    for (int k = lo; k <= hi; k++) begin
      if (bracket_img[k]) begin
        if (depth > 0) depth--;
        else stray++;
      end else begin
        depth++;
      end
    end
    tot = depth + stray;
    if (tot > int'(COUNT_MAX)) return COUNT_MAX;
    return tot[CNT_W-1:0];
  endfunction

  // Apply one accepted beat to the mirror; a query leaves its count behind.
  task automatic track_command(input bracket_cmd_t c);
    int p;
    int lo;
    int hi;
    p = int'(c.pos);
    case (c.op)
      OP_WRITE: begin
        n_write++;
        if (p >= 1 && p <= MAX_LEN) bracket_img[p] = c.bit_in;
      end
      OP_FLIP: begin
        n_flip++;
        if (p >= 1 && p <= MAX_LEN) bracket_img[p] = ~bracket_img[p];
      end
      OP_QUERY: begin
        n_query++;
        lo = (p < 1) ? 1 : p;
        hi = (int'(c.rend) > MAX_LEN) ? MAX_LEN : int'(c.rend);
        if (hi - lo + 1 > widest) widest = hi - lo + 1;
        count_due.push_back(unmatched_in(p, int'(c.rend)));
      end
      default: n_idle_op++;
    endcase
  endtask

  // Take beats and check results at the rising edge. Check before taking a new
  // beat: a result and the next command may share an edge.
  always @(posedge clk_i) begin
    beat_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o) begin
        if (count_due.size() == 0) begin
          $display("%0t: fix_count result with none expected, actual %0d",
                   $time, fix_count_o);
          fail_count++;
        end else begin
          if (fix_count_o !== count_due[0]) begin
            $display("%0t: fix_count mismatch, expected %0d, actual %0d",
                     $time, count_due[0], fix_count_o);
            fail_count++;
          end
          void'(count_due.pop_front());
          n_checked++;
        end
      end
      if (cmd_start && !busy) begin
        beat_taken = 1'b1;
        n_beats++;
        track_command({cmd_op, cmd_pos, cmd_rend, cmd_bit});
      end
    end
  end

  // Drive at the falling edge: hold a beat until it is taken, then advance to the
  // next one or idle now and then, except in the calm window.
  always @(negedge clk_i) begin
    if (rst_ni && (!cmd_start || beat_taken)) begin
      if (cmd_backlog.size() != 0 &&
          ((n_beats >= CALM_FROM && n_beats < CALM_TO) || $urandom_range(99) >= 10)) begin
        next_cmd = cmd_backlog.pop_front();
        cmd_start <= 1'b1;
        cmd_op    <= next_cmd.op;
        cmd_pos   <= next_cmd.pos;
        cmd_rend  <= next_cmd.rend;
        cmd_bit   <= next_cmd.bit_in;
      end else begin
        cmd_start <= 1'b0;
      end
    end
  end

  // Queue one command; unused fields carry random noise. A write inside the store
  // marks its position as safe to read later.
  task automatic queue_cmd(input logic [OP_W-1:0] op, input int p, input int r, input int b);
    bracket_cmd_t c;
    c.op     = op;
    c.pos    = p[POS_W-1:0];
    c.rend   = r[POS_W-1:0];
    c.bit_in = b[0];
    if (op == OP_WRITE && p >= 1 && p <= MAX_LEN) loaded[p] = 1'b1;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_write(input int p, input int b);
    queue_cmd(OP_WRITE, p, $urandom_range(POS_TOP), b);
  endtask

  task automatic queue_flip(input int p);
    queue_cmd(OP_FLIP, p, $urandom_range(POS_TOP), $urandom_range(1));
  endtask

  task automatic queue_query(input int l, input int r);
    queue_cmd(OP_QUERY, l, r, $urandom_range(1));
  endtask

  // Any position already written; the directed part leaves several behind.
  function automatic int pick_loaded();
    int p;
    do p = $urandom_range(MAX_LEN, 1); while (!loaded[p]);
    return p;
  endfunction

  // Query inside the written run around p, so no unwritten entry is ever read.
  // Stretch the ends past the store when the run touches them.
  task automatic probe_run(input int p);
    int lo;
    int hi;
    int l;
    int r;
    lo = p;
    hi = p;
    while (lo > 1 && loaded[lo-1]) lo--;
    while (hi < MAX_LEN && loaded[hi+1]) hi++;
    case ($urandom_range(3))
      0: begin
        l = lo;
        r = hi;
      end
      1: begin
        l = $urandom_range(hi, lo);
        r = l;
      end
      default: begin
        l = $urandom_range(hi, lo);
        r = $urandom_range(hi, l);
      end
    endcase
    if (hi == MAX_LEN && r == hi && $urandom_range(1)) r = $urandom_range(POS_TOP, MAX_LEN);
    if (l == 1 && $urandom_range(1)) l = 0;
    queue_query(l, r);
  endtask

  // Load a run of brackets: random, near-balanced, all openers, all closers, or
  // closers then openers (every bracket unmatched).
  task automatic load_segment(input int a, input int len, input int shape);
    int depth;
    int b;
    depth = 0;
    for (int k = 0; k < len; k++) begin
      case (shape)
        0: b = $urandom_range(1);
        1: begin
          if (depth == len - k) b = 1;
          else if (depth == 0) b = 0;
          else b = $urandom_range(1);
        end
        2: b = 0;
        3: b = 1;
        default: b = (k < len / 2) ? 1 : 0;
      endcase
      if (b == 0) depth++;
      else if (depth > 0) depth--;
      queue_write(a + k, b);
    end
  endtask

  initial begin
    int sel;
    int len_sel;
    int a;
    int len;
    int lo;

    // Directed part: store edges, ignored positions, clipping, empty ranges, flips.
    queue_write(1, 0);
    queue_write(2, 1);
    queue_query(1, 2);
    queue_write(MAX_LEN, 1);
    queue_write(MAX_LEN - 1, 0);
    queue_query(MAX_LEN - 1, POS_TOP);     // right end beyond the store
    queue_query(MAX_LEN, MAX_LEN);
    queue_write(0, 1);                     // dropped: position zero
    queue_write(POS_TOP, 1);               // dropped: beyond the store
    queue_flip(0);
    queue_flip(MAX_LEN + 1);
    queue_flip(2);
    queue_query(1, 2);
    queue_query(2, 1);                     // empty range
    queue_query(POS_TOP, POS_TOP);         // wholly beyond the store
    queue_query(0, 2);                     // left end clipped to one
    queue_cmd(OP_UNUSED, 1, POS_TOP, 1);
    queue_query(1, 1);
    queue_flip(MAX_LEN);
    queue_query(MAX_LEN - 1, MAX_LEN);
    queue_query(0, 0);

    // Random part: mostly load-then-probe sequences, plus single probes and noise.
    while (cmd_backlog.size() < ITEM_TARGET) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        len_sel = $urandom_range(99);
        if (len_sel < 85) len = $urandom_range(16, 1);
        else if (len_sel < 97) len = $urandom_range(48, 17);
        else len = $urandom_range(160, 49);
        a = $urandom_range(MAX_LEN, 1);
        if (a + len - 1 > MAX_LEN) len = MAX_LEN - a + 1;
        load_segment(a, len, $urandom_range(4));
        repeat ($urandom_range(3, 1)) begin
          if ($urandom_range(3) == 0) queue_flip(a + $urandom_range(len - 1));
          else probe_run(a + $urandom_range(len - 1));
        end
      end else if (sel < 80) begin
        probe_run(pick_loaded());
      end else begin
        case ($urandom_range(5))
          0: queue_write($urandom_range(POS_TOP), $urandom_range(1));
          1: begin
            a = $urandom_range(1) ? 0 : $urandom_range(POS_TOP, MAX_LEN + 1);
            if ($urandom_range(1)) queue_write(a, $urandom_range(1));
            else queue_flip(a);
          end
          2: queue_flip(pick_loaded());
          3: queue_cmd(OP_UNUSED, $urandom_range(POS_TOP), $urandom_range(POS_TOP),
                       $urandom_range(1));
          4: begin
            lo = $urandom_range(POS_TOP - 1);
            queue_query($urandom_range(POS_TOP, lo + 1), lo);
          end
          default: queue_query($urandom_range(POS_TOP, MAX_LEN + 1), $urandom_range(POS_TOP));
        endcase
      end
    end

    repeat (2) @(posedge clk_i);
    #2 rst_ni = 1'b1;

    // Drain: every beat taken, every count back, then a short pause for a flip
    // still in flight.
    while (cmd_backlog.size() != 0 || cmd_start) @(posedge clk_i);
    while (count_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d beats: %0d writes, %0d flips, %0d queries, %0d unused ops.",
             n_beats, n_write, n_flip, n_query, n_idle_op);
    $display("Checked %0d fix counts; widest clipped range scanned %0d positions.",
             n_checked, widest);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard, well beyond a run of full-store queries.
  initial begin
    #40_000_000;
    $display("Timeout waiting for the block to drain");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
